// ----- rtl/mrs_pkg.sv -----
package mrs_pkg;

  localparam logic [15:0] CRC_INIT = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [7:0]  FN_READ  = 8'h03;
  localparam logic [7:0]  FN_WRITE = 8'h06;
  localparam logic [15:0] CMD_REG  = 16'd19;
  localparam int          MIN_LEN  = 8;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_CRC_RD,
    ST_CRC_FEED,
    ST_CRC_FIN,
    ST_VERIFY,
    ST_READ,
    ST_ECHO_RD,
    ST_ECHO_OUT
  } state_t;

  typedef struct packed {
    logic       init;
    logic       load;
    logic [7:0] data;
  } crc_ctl_t;

endpackage

// ----- rtl/mrs_crc.sv -----
module mrs_crc (
  input  logic             clk,
  input  logic             rst_n,
  input  mrs_pkg::crc_ctl_t ctl,
  output logic [15:0]      crc,
  output logic             busy
);

  logic [15:0] crc_r, crc_nxt;
  logic [3:0]  bit_r, bit_nxt;

  always_comb begin
    crc_nxt = crc_r;
    bit_nxt = bit_r;
    priority if (ctl.init) begin
      crc_nxt = mrs_pkg::CRC_INIT;
      bit_nxt = 4'd0;
    end else if (ctl.load) begin
      crc_nxt = crc_r ^ {8'h00, ctl.data};
      bit_nxt = 4'd8;
    end else if (bit_r != 4'd0) begin
      crc_nxt = crc_r[0] ? ((crc_r >> 1) ^ mrs_pkg::CRC_POLY) : (crc_r >> 1);
      bit_nxt = bit_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= mrs_pkg::CRC_INIT;
      bit_r <= 4'd0;
    end else begin
      crc_r <= crc_nxt;
      bit_r <= bit_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (bit_r != 4'd0);

endmodule

// ----- rtl/modbus_rtu_register_slave.sv -----
// channel | dir | tdata (low bit up)                        | tuser | tlast
// in_     | in  | rx_byte, load_index, load_value, zero pad | func  | frame_end
// out_    | out | tx_byte, drive_bits, zero pad             | -     | tx_last
// cfg_    | in  | device_address                            | -     | -
// a byte or table load is accepted whenever idle; a closing byte is followed by a crc walk
// over the stored frame on the bit-serial crc unit; a read response waits for the crc unit
// before each byte, an echo replays the stored frame; in_tready is low from frame close
// until the frame is dropped or the last response byte is in the output register
// output stalls only hold the response; reset clears the table and command word
module modbus_rtu_register_slave #(
  parameter int FRAME_BYTES = 64,
  parameter int TABLE_WORDS = 24
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // device_address
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,      // rx_byte, load_index, load_value
  input  logic        in_tuser,      // func
  input  logic        in_tlast,      // frame_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,     // tx_byte, drive_bits
  output logic        out_tlast      // tx_last
);

  localparam int AW = $clog2(FRAME_BYTES);
  localparam int CW = $clog2(FRAME_BYTES + 1);
  localparam int TW = $clog2(TABLE_WORDS);
  localparam int PW = $clog2(FRAME_BYTES + 2 * TABLE_WORDS + 6);

  mrs_pkg::state_t st_r, st_nxt;
  logic [CW-1:0] cnt_r, len_r;
  logic [PW-1:0] pos_r, pos_nxt, ntot_r, ntot_nxt;
  logic [7:0]    hdr_r [6];
  logic [7:0]    lb0_r, lb1_r, dev_r, mem_q_r;
  logic [15:0]   cmd_r;
  logic [15:0]   tab_r [TABLE_WORDS];
  logic [7:0]    mem [FRAME_BYTES];
  logic          ovalid_r, olast_r;
  logic [7:0]    obyte_r;
  logic [3:0]    odrive_r;

  mrs_pkg::crc_ctl_t crc_ctl;
  logic [15:0]   crc_val;
  logic          crc_busy;

  logic          in_acc, slot_free, ld_out, ld_last, cmd_we, range_ok;
  logic [7:0]    ld_byte, in_rx, resp_byte;
  logic [4:0]    in_lidx;
  logic [15:0]   in_lval, rd_addr, rd_qty, word;
  logic [CW-1:0] cnt_inc;
  logic [PW-1:0] len_p, word_off;
  logic [15:0]   tidx;

  mrs_crc u_crc (
    .clk  (clk),
    .rst_n(rst_n),
    .ctl  (crc_ctl),
    .crc  (crc_val),
    .busy (crc_busy)
  );

  assign in_rx   = in_tdata[7:0];
  assign in_lidx = in_tdata[12:8];
  assign in_lval = in_tdata[28:13];
  assign in_tready = (st_r == mrs_pkg::ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign slot_free = !ovalid_r || out_tready;
  assign cnt_inc   = (cnt_r < CW'(FRAME_BYTES)) ? cnt_r + CW'(1) : cnt_r;
  assign len_p     = PW'(len_r);

  assign rd_addr  = {hdr_r[2], hdr_r[3]};
  assign rd_qty   = {hdr_r[4], hdr_r[5]};
  assign range_ok = (rd_qty != 16'd0) &&
                    (({1'b0, rd_addr} + {1'b0, rd_qty}) <= 17'(TABLE_WORDS));
  assign word_off = (pos_r - PW'(3)) >> 1;
  assign tidx     = rd_addr + 16'(word_off);
  assign word     = (tidx < 16'(TABLE_WORDS)) ? tab_r[tidx[TW-1:0]] : 16'd0;

  always_comb begin
    priority if (pos_r == PW'(0))             resp_byte = dev_r;
    else if (pos_r == PW'(1))                 resp_byte = mrs_pkg::FN_READ;
    else if (pos_r == PW'(2))                 resp_byte = {rd_qty[6:0], 1'b0};
    else if (pos_r == ntot_r - PW'(2))        resp_byte = crc_val[7:0];
    else if (pos_r == ntot_r - PW'(1))        resp_byte = crc_val[15:8];
    else if (pos_r[0])                        resp_byte = word[15:8];
    else                                      resp_byte = word[7:0];
  end

  always_comb begin
    st_nxt   = st_r;
    pos_nxt  = pos_r;
    ntot_nxt = ntot_r;
    crc_ctl  = '0;
    ld_out   = 1'b0;
    ld_byte  = mem_q_r;
    ld_last  = 1'b0;
    cmd_we   = 1'b0;
    unique case (st_r)
      mrs_pkg::ST_IDLE: begin
        if (in_acc && !in_tuser && in_tlast) st_nxt = mrs_pkg::ST_CHECK;
      end
      mrs_pkg::ST_CHECK: begin
        if (len_r < CW'(mrs_pkg::MIN_LEN) || hdr_r[0] != dev_r) begin
          st_nxt = mrs_pkg::ST_IDLE;
        end else begin
          crc_ctl.init = 1'b1;
          pos_nxt = '0;
          st_nxt  = mrs_pkg::ST_CRC_RD;
        end
      end
      mrs_pkg::ST_CRC_RD: begin
        if (!crc_busy) st_nxt = mrs_pkg::ST_CRC_FEED;
      end
      mrs_pkg::ST_CRC_FEED: begin
        crc_ctl.load = 1'b1;
        crc_ctl.data = mem_q_r;
        pos_nxt = pos_r + PW'(1);
        st_nxt  = (pos_r + PW'(1) == len_p - PW'(2)) ? mrs_pkg::ST_CRC_FIN
                                                     : mrs_pkg::ST_CRC_RD;
      end
      mrs_pkg::ST_CRC_FIN: begin
        if (!crc_busy) st_nxt = mrs_pkg::ST_VERIFY;
      end
      mrs_pkg::ST_VERIFY: begin
        pos_nxt = '0;
        st_nxt  = mrs_pkg::ST_IDLE;
        if (crc_val == {lb0_r, lb1_r}) begin
          if (hdr_r[1] == mrs_pkg::FN_READ && range_ok) begin
            crc_ctl.init = 1'b1;
            ntot_nxt = PW'({rd_qty[6:0], 1'b0}) + PW'(5);
            st_nxt   = mrs_pkg::ST_READ;
          end else if (hdr_r[1] == mrs_pkg::FN_WRITE && rd_addr == mrs_pkg::CMD_REG) begin
            cmd_we = 1'b1;
            st_nxt = mrs_pkg::ST_ECHO_RD;
          end
        end
      end
      mrs_pkg::ST_READ: begin
        if (slot_free && !crc_busy) begin
          ld_out  = 1'b1;
          ld_byte = resp_byte;
          ld_last = (pos_r == ntot_r - PW'(1));
          if (pos_r < ntot_r - PW'(2)) begin
            crc_ctl.load = 1'b1;
            crc_ctl.data = resp_byte;
          end
          pos_nxt = pos_r + PW'(1);
          if (ld_last) st_nxt = mrs_pkg::ST_IDLE;
        end
      end
      mrs_pkg::ST_ECHO_RD: begin
        st_nxt = mrs_pkg::ST_ECHO_OUT;
      end
      mrs_pkg::ST_ECHO_OUT: begin
        if (slot_free) begin
          ld_out  = 1'b1;
          ld_last = (pos_r == len_p - PW'(1));
          pos_nxt = pos_r + PW'(1);
          st_nxt  = ld_last ? mrs_pkg::ST_IDLE : mrs_pkg::ST_ECHO_RD;
        end
      end
      default: st_nxt = mrs_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= mrs_pkg::ST_IDLE;
      cnt_r    <= '0;
      pos_r    <= '0;
      ovalid_r <= 1'b0;
      dev_r    <= 8'd1;
      cmd_r    <= 16'd0;
    end else begin
      st_r  <= st_nxt;
      pos_r <= pos_nxt;
      if (cfg_wr_en) dev_r <= cfg_wr_data;
      if (cmd_we) cmd_r <= rd_qty;
      if (in_acc && !in_tuser) cnt_r <= in_tlast ? '0 : cnt_inc;
      if (ld_out) ovalid_r <= 1'b1;
      else if (out_tready) ovalid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_WORDS; i++) tab_r[i] <= 16'd0;
    end else begin
      if (in_acc && in_tuser && ({27'd0, in_lidx} < 32'(TABLE_WORDS)))
        tab_r[in_lidx[TW-1:0]] <= in_lval;
      if (cmd_we) tab_r[mrs_pkg::CMD_REG[TW-1:0]] <= rd_qty;
    end
  end

  always_ff @(posedge clk) begin
    ntot_r  <= ntot_nxt;
    mem_q_r <= mem[pos_r[AW-1:0]];
    if (in_acc && !in_tuser) begin
      if (cnt_r < CW'(FRAME_BYTES)) begin
        mem[cnt_r[AW-1:0]] <= in_rx;
        lb0_r <= in_rx;
        lb1_r <= lb0_r;
        for (int i = 0; i < 6; i++)
          if (cnt_r == CW'(i)) hdr_r[i] <= in_rx;
      end
      if (in_tlast) len_r <= cnt_inc;
    end
    if (ld_out) begin
      obyte_r  <= ld_byte;
      olast_r  <= ld_last;
      odrive_r <= cmd_r[3:0];
    end
  end

  assign out_tvalid = ovalid_r;
  assign out_tdata  = {4'd0, odrive_r, obyte_r};
  assign out_tlast  = olast_r;

`ifndef SYNTHESIS
  a_idle_crc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !crc_busy) else $error("crc unit busy while idle");
  a_load_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    crc_ctl.load |-> !crc_busy) else $error("crc load while busy");
  a_verify_len: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == mrs_pkg::ST_VERIFY) |-> (len_r >= CW'(mrs_pkg::MIN_LEN)))
    else $error("short frame reached verify");
`endif

endmodule
